@@ hw/rtl/tbp_pkg.sv @@
package tbp_pkg;

  localparam int CLIENT_W = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int LEVEL_W  = 26;
  localparam int PROD_W   = TIME_W + CFG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // One token expressed in milli-tokens.
  localparam logic [LEVEL_W-1:0] MILLI_PER_TOKEN = LEVEL_W'(1000);

  // Register indexes, decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_RATE     = 1'b1;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(3);
  localparam logic [CFG_W-1:0] RATE_RESET     = CFG_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_UPDATE
  } tbp_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  stamp;
  } tbp_entry_t;

endpackage

@@ hw/rtl/tbp_table.sv @@
module tbp_table import tbp_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output tbp_entry_t       rd_data,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  tbp_entry_t       wr_data
);

  tbp_entry_t       mem [DEPTH];
  tbp_entry_t       rd_data_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_valid_r;

  // Entry storage has no reset; the valid bits tell which entries hold data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

@@ hw/rtl/token_bucket_policer.sv @@
// Per-client token-bucket policer. A request (client index and millisecond
// time) is taken at a rising edge where start is high and busy is low. Each
// request goes through three steps: the accept cycle reads the client's
// entry from the table memory, the next cycle forms the elapsed time and
// multiplies it by the refill rate, and the third adds, saturates at the
// capacity, takes a token if one is there and writes the entry back. busy
// is high in the refill and update steps. out_valid flags the verdict on
// out_allowed for exactly one cycle, in the cycle after the write-back, when
// the next request may be accepted; out_allowed holds it until the next
// verdict. There is no way to hold a result off: the receiver must capture
// it in that cycle. Requests whose client index is at or beyond NUM_CLIENTS
// are answered with out_allowed low and leave the table as it is. Reset
// clears the per-client valid bits at once, so no clearing pass is needed.
// The user must write configuration over the APB port only while the block
// is idle; the block itself does not enforce this.
module token_bucket_policer import tbp_pkg::*; #(
  parameter int NUM_CLIENTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel.
  input  logic                start,
  output logic                busy,
  input  logic [CLIENT_W-1:0] in_client_index,
  input  logic [TIME_W-1:0]   in_time_ms,
  // Result channel.
  output logic                out_valid,
  output logic                out_allowed,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int EXT_W = (IDX_W > CLIENT_W) ? IDX_W : CLIENT_W;

  // Configuration registers.
  logic [CFG_W-1:0] capacity_r;
  logic [CFG_W-1:0] rate_r;
  logic             cfg_write;

  // Request pipeline state.
  tbp_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               in_range_r, in_range_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [LEVEL_W-1:0] base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_allowed_r, out_allowed_nxt;

  // Table access.
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  tbp_entry_t         rd_data;
  logic               rd_valid;
  logic               wr_en;
  tbp_entry_t         wr_data;

  // Datapath intermediates.
  logic [EXT_W-1:0]   idx_ext;
  logic               idx_in_range;
  logic [LEVEL_W-1:0] limit;
  logic [TIME_W-1:0]  elapsed;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] sat_level;
  logic               token_ok;

  // ---------------------------------------------------------------------
  // APB configuration. Registers are word aligned and decoded on paddr[2].
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      rate_r     <= RATE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CAPACITY: capacity_r <= pwdata[CFG_W-1:0];
        REG_RATE:     rate_r     <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = DATA_W'(capacity_r);
      REG_RATE:     prdata = DATA_W'(rate_r);
      default:      prdata = '0;
    endcase
  end

  // The saturation limit in milli-tokens always fits the level width.
  assign limit = LEVEL_W'(32'(capacity_r) * 32'(MILLI_PER_TOKEN));

  // ---------------------------------------------------------------------
  // Index decode on the incoming request.
  // ---------------------------------------------------------------------
  assign idx_ext      = EXT_W'(in_client_index);
  assign rd_idx       = idx_ext[IDX_W-1:0];
  assign idx_in_range = (32'(in_client_index) < 32'(NUM_CLIENTS));

  tbp_table #(
    .DEPTH (NUM_CLIENTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_idx   (idx_r),
    .wr_data  (wr_data)
  );

  // ---------------------------------------------------------------------
  // Request sequencer: read, refill product, then update and write back.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    time_nxt        = time_r;
    in_range_nxt    = in_range_r;
    prod_nxt        = prod_r;
    base_nxt        = base_r;
    out_valid_nxt   = 1'b0;
    out_allowed_nxt = out_allowed_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    elapsed         = '0;
    sum             = SUM_W'(base_r) + SUM_W'(prod_r);
    sat_level       = (sum > SUM_W'(limit)) ? limit : sum[LEVEL_W-1:0];
    token_ok        = (sat_level >= MILLI_PER_TOKEN);
    wr_data.level   = token_ok ? (sat_level - MILLI_PER_TOKEN) : sat_level;
    wr_data.stamp   = time_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_en        = 1'b1;
          idx_nxt      = rd_idx;
          time_nxt     = in_time_ms;
          in_range_nxt = idx_in_range;
          state_nxt    = ST_REFILL;
        end
      end
      ST_REFILL: begin
        // A client seen for the first time starts full with no elapsed time.
        if (rd_valid) begin
          elapsed  = time_r - rd_data.stamp;
          base_nxt = rd_data.level;
        end else begin
          elapsed  = '0;
          base_nxt = limit;
        end
        prod_nxt  = PROD_W'(elapsed) * PROD_W'(rate_r);
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr_en           = in_range_r;
        out_valid_nxt   = 1'b1;
        out_allowed_nxt = in_range_r && token_ok;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    time_r        <= time_nxt;
    in_range_r    <= in_range_nxt;
    prod_r        <= prod_nxt;
    base_r        <= base_nxt;
    out_allowed_r <= out_allowed_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;

endmodule
